FILE: design/far_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// far_pkg
// Shared constants and types for the fraction add-and-reduce core.
// ----------------------------------------------------------------------------
package far_pkg;

    // Default numerator width; denominators are one bit narrower
    localparam int OPERAND_WIDTH_DEF = 16;

    // Fixed result field widths
    localparam int SUM_NUM_W = 32;
    localparam int SUM_DEN_W = 30;

    // Status of an iterative arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

FILE: design/far_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// far_in_if
// Input channel: two fractions per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface far_in_if #(
    parameter int OPERAND_WIDTH = far_pkg::OPERAND_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic        [OPERAND_WIDTH-2:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic        [OPERAND_WIDTH-2:0] b_den;

    modport source (output valid, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, a_num, a_den, b_num, b_den, output ready);
endinterface

FILE: design/far_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// far_out_if
// Output channel: one reduced fraction per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface far_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [far_pkg::SUM_NUM_W-1:0] sum_num;
    logic        [far_pkg::SUM_DEN_W-1:0] sum_den;

    modport source (output valid, sum_num, sum_den, input ready);
    modport sink   (input valid, sum_num, sum_den, output ready);
endinterface

FILE: design/far_gcd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// far_gcd
// Iterative binary GCD: one halving or one subtract-and-halve per cycle,
// common factors of two counted and restored by a final shift.
// ----------------------------------------------------------------------------
module far_gcd #(
    parameter int MW = 2 * far_pkg::OPERAND_WIDTH_DEF - 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MW-1:0]     i_x,
    input  logic [MW-1:0]     i_y,
    output logic [MW-1:0]     o_g,
    output far_pkg::t_unit_sts o_sts
);
    localparam int KW = $clog2(MW + 1);

    logic          r_busy;
    logic          r_done;
    logic [MW-1:0] r_x;
    logic [MW-1:0] r_y;
    logic [KW-1:0] r_k;
    logic [MW-1:0] r_g;

    // shared compare / subtract unit
    logic          x_ge_y;
    logic [MW-1:0] big;
    logic [MW-1:0] sml;
    logic [MW-1:0] diff;

    assign x_ge_y = (r_x >= r_y);
    assign big    = x_ge_y ? r_x : r_y;
    assign sml    = x_ge_y ? r_y : r_x;
    assign diff   = big - sml;

    // iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_x    <= i_x;
                r_y    <= i_y;
                r_k    <= '0;
            end else if (r_busy) begin
                if (r_y == '0) begin
                    r_g    <= r_x << r_k;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (r_x == '0) begin
                    r_g    <= r_y << r_k;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1;
                    r_y <= r_y >> 1;
                    r_k <= r_k + KW'(1);
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (x_ge_y) begin
                    r_x <= diff >> 1;
                end else begin
                    r_y <= diff >> 1;
                end
            end
        end
    end

    assign o_g        = r_g;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

FILE: design/far_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// far_div
// Restoring divider, one quotient bit per cycle, two dividend lanes that
// share one divisor (numerator magnitude and denominator over the GCD).
// ----------------------------------------------------------------------------
module far_div #(
    parameter int MW = 2 * far_pkg::OPERAND_WIDTH_DEF - 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MW-1:0]     i_dvd0,
    input  logic [MW-1:0]     i_dvd1,
    input  logic [MW-1:0]     i_dvs,
    output logic [MW-1:0]     o_quo0,
    output logic [MW-1:0]     o_quo1,
    output far_pkg::t_unit_sts o_sts
);
    localparam int CW = $clog2(MW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [MW-1:0] r_dvs;
    logic [MW-1:0] r_q   [2];
    logic [MW-1:0] r_rem [2];
    logic [MW:0]   trial [2];

    // trial subtract per lane
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            trial[l] = {r_rem[l], r_q[l][MW-1]} - {1'b0, r_dvs};
        end
    end

    // step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_cnt    <= CW'(MW - 1);
                r_dvs    <= i_dvs;
                r_q[0]   <= i_dvd0;
                r_q[1]   <= i_dvd1;
                r_rem[0] <= '0;
                r_rem[1] <= '0;
            end else if (r_busy) begin
                for (int l = 0; l < 2; l++) begin
                    if (!trial[l][MW]) begin
                        r_rem[l] <= trial[l][MW-1:0];
                        r_q[l]   <= {r_q[l][MW-2:0], 1'b1};
                    end else begin
                        r_rem[l] <= {r_rem[l][MW-2:0], r_q[l][MW-1]};
                        r_q[l]   <= {r_q[l][MW-2:0], 1'b0};
                    end
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
        end
    end

    assign o_quo0     = r_q[0];
    assign o_quo1     = r_q[1];
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

FILE: design/fraction_add_reduce_core.sv
`timescale 1ns / 1ps
// Sequence: accept, then the products a_num*b_den, b_num*a_den and a_den*b_den,
//   the sum and its magnitude; a zero sum then goes straight to the final step,
//   otherwise the binary GCD loop and the bit-serial divider run before it.
// Throughput: one transaction at a time; the GCD loop and the bit-serial
//   divider bound it. A new input is taken while a result waits; a result
//   still held at the output stalls the next one in its final step.
// Reset: synchronous, active low; clears the sequencer and the valid flags.
// ----------------------------------------------------------------------------
// fraction_add_reduce_core
// Adds two fractions via one shared multiplier, then reduces the sum by its
// GCD using an iterative binary GCD unit and a two-lane restoring divider.
// ----------------------------------------------------------------------------
module fraction_add_reduce_core #(
    parameter int OPERAND_WIDTH = far_pkg::OPERAND_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    far_in_if.sink           i_in,
    far_out_if.source        o_out
);
    localparam int W   = OPERAND_WIDTH;
    localparam int PW  = 2 * W;
    localparam int MW  = 2 * W - 1;
    localparam int NXW = (MW + 1 > far_pkg::SUM_NUM_W) ? MW + 1 : far_pkg::SUM_NUM_W;
    localparam int DXW = (MW > far_pkg::SUM_DEN_W) ? MW : far_pkg::SUM_DEN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_MUL_D,
        S_SUM,
        S_MAG,
        S_GCD,
        S_DIV
    } t_state;

    t_state r_state;
    logic   r_done_wait;

    // operand and intermediate registers
    logic signed [W-1:0]  r_an;
    logic signed [W-1:0]  r_bn;
    logic        [W-2:0]  r_ad;
    logic        [W-2:0]  r_bd;
    logic signed [PW-1:0] r_p1;
    logic signed [PW-1:0] r_p2;
    logic signed [PW-1:0] r_s;
    logic        [MW-1:0] r_den;
    logic        [MW-1:0] r_mag;
    logic                 r_neg;
    logic                 r_zero;

    logic                                 r_out_valid;
    logic signed [far_pkg::SUM_NUM_W-1:0] r_sum_num;
    logic        [far_pkg::SUM_DEN_W-1:0] r_sum_den;

    // shared multiplier
    logic signed [W-1:0]  mul_a;
    logic signed [W-1:0]  mul_b;
    logic signed [PW-1:0] mul_p;

    always_comb begin
        case (r_state)
            S_MUL_A: begin
                mul_a = r_an;
                mul_b = signed'({1'b0, r_bd});
            end
            S_MUL_B: begin
                mul_a = r_bn;
                mul_b = signed'({1'b0, r_ad});
            end
            default: begin
                mul_a = signed'({1'b0, r_ad});
                mul_b = signed'({1'b0, r_bd});
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // GCD and divider units
    logic               gcd_start;
    logic [MW-1:0]      gcd_g;
    far_pkg::t_unit_sts gcd_sts;
    logic               div_start;
    logic [MW-1:0]      quo_num;
    logic [MW-1:0]      quo_den;
    far_pkg::t_unit_sts div_sts;

    assign gcd_start = (r_state == S_MAG) && (r_s != '0);
    assign div_start = (r_state == S_GCD) && gcd_sts.done;

    far_gcd #(.MW(MW)) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gcd_start),
        .i_x     (MW'(r_s[PW-1] ? -r_s : r_s)),
        .i_y     (r_den),
        .o_g     (gcd_g),
        .o_sts   (gcd_sts)
    );

    far_div #(.MW(MW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd0  (r_mag),
        .i_dvd1  (r_den),
        .i_dvs   (gcd_g),
        .o_quo0  (quo_num),
        .o_quo1  (quo_den),
        .o_sts   (div_sts)
    );

    // result formatting: sign restore and field truncation
    logic [NXW-1:0] num_ext;
    logic [NXW-1:0] num_sgn;
    logic [DXW-1:0] den_ext;
    logic           res_ready;
    logic           out_free;

    assign num_ext   = NXW'(quo_num);
    assign num_sgn   = r_neg ? ('0 - num_ext) : num_ext;
    assign den_ext   = DXW'(quo_den);
    assign out_free  = !r_out_valid || o_out.ready;
    assign res_ready = r_done_wait && out_free;

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done_wait <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // result register: load a finished sum, clear once taken
            if (res_ready) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_an    <= i_in.a_num;
                        r_bn    <= i_in.b_num;
                        r_ad    <= i_in.a_den;
                        r_bd    <= i_in.b_den;
                        r_state <= S_MUL_A;
                    end
                end
                S_MUL_A: begin
                    r_p1    <= mul_p;
                    r_state <= S_MUL_B;
                end
                S_MUL_B: begin
                    r_p2    <= mul_p;
                    r_state <= S_MUL_D;
                end
                S_MUL_D: begin
                    r_den   <= mul_p[MW-1:0];
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_s     <= r_p1 + r_p2;
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_neg  <= r_s[PW-1];
                    r_mag  <= MW'(r_s[PW-1] ? -r_s : r_s);
                    r_zero <= (r_s == '0);
                    if (r_s == '0) begin
                        r_done_wait <= 1'b1;
                        r_state     <= S_DIV;
                    end else begin
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (gcd_sts.done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (res_ready) begin
                        r_done_wait <= 1'b0;
                        r_state     <= S_IDLE;
                        if (r_zero) begin
                            r_sum_num <= '0;
                            r_sum_den <= {{(far_pkg::SUM_DEN_W-1){1'b0}}, 1'b1};
                        end else begin
                            r_sum_num <= signed'(num_sgn[far_pkg::SUM_NUM_W-1:0]);
                            r_sum_den <= den_ext[far_pkg::SUM_DEN_W-1:0];
                        end
                    end else if (div_sts.done) begin
                        r_done_wait <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.sum_num = r_sum_num;
    assign o_out.sum_den = r_sum_den;

    // checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while a transaction is in flight");

    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gcd_sts.done |-> (gcd_g != '0))
        else $error("GCD unit returned zero");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(gcd_sts.busy && div_sts.busy))
        else $error("GCD and divider active together");

    a_result_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_state == S_DIV))
        else $error("result loaded outside the final step");

endmodule

FILE: dv/tb_fraction_add_reduce_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fraction_add_reduce_core
// Self-checking bench for the fraction add-and-reduce core. Every accepted
// operand pair goes through a behavioral rational adder with exact GCD
// reduction, and each result transaction is matched in order, field by field.
// A directed set covers operand extremes, zero sums and zero denominators.
// Random pairs follow. Both sides of the handshake idle at random. The result
// side also backs up once for a long stretch, and the operand side also
// pauses once until every pending sum has drained.
// ----------------------------------------------------------------------------
module tb_fraction_add_reduce_core;

    localparam int OPW            = far_pkg::OPERAND_WIDTH_DEF;
    localparam int N_RANDOM       = 1300;
    localparam int HOLD_AT_RESULT = 400;
    localparam int HOLD_CYCLES    = 500;
    localparam int PAUSE_AT_ITEM  = 700;
    localparam int DRAIN_CYCLES   = 200;

    typedef logic signed [OPW-1:0] t_num;
    typedef logic        [OPW-2:0] t_den;
    typedef longint unsigned       t_u64;

    typedef struct {
        logic signed [far_pkg::SUM_NUM_W-1:0] num;
        logic        [far_pkg::SUM_DEN_W-1:0] den;
    } t_fraction;

    localparam t_num NUM_MAX = {1'b0, {(OPW-1){1'b1}}};
    localparam t_num NUM_MIN = {1'b1, {(OPW-1){1'b0}}};
    localparam t_den DEN_MAX = '1;

    // Reduced-sum predictor and in-order store of pending sums
    class sum_checker;
        t_fraction owed_sums[$];
        int        n_mismatch;

        function new();
            n_mismatch = 0;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            n_mismatch++;
        endtask

        function int owed();
            return owed_sums.size();
        endfunction

        // Cross-multiplied sum, then divide both parts by their true GCD
        function void note_operands(t_num an, t_den ad, t_num bn, t_den bd);
            longint    s;
            t_u64      den, mag, x, y, r, rn, rd;
            t_fraction f;
            s   = longint'(an) * longint'(bd) + longint'(bn) * longint'(ad);
            den = t_u64'(ad) * t_u64'(bd);
            if (s == 0) begin
                f.num = '0;
                f.den = {{(far_pkg::SUM_DEN_W-1){1'b0}}, 1'b1};
            end else begin
                mag = (s < 0) ? t_u64'(-s) : t_u64'(s);
                x = mag;
                y = den;
                while (y != 0) begin
                    r = x % y;
                    x = y;
                    y = r;
                end
                if (x == 0)
                    x = 1;
                rn = mag / x;
                rd = den / x;
                if (s < 0)
                    rn = -rn;
                f.num = rn[far_pkg::SUM_NUM_W-1:0];
                f.den = rd[far_pkg::SUM_DEN_W-1:0];
            end
            owed_sums.push_back(f);
        endfunction

        task check_sum(logic signed [far_pkg::SUM_NUM_W-1:0] num,
                       logic [far_pkg::SUM_DEN_W-1:0] den);
            t_fraction want;
            if (owed_sums.size() == 0) begin
                report_mismatch($sformatf("result %0d/%0d with no sum pending", num, den));
                return;
            end
            want = owed_sums.pop_front();
            if (num !== want.num)
                report_mismatch($sformatf("sum_num got %0d want %0d", num, want.num));
            if (den !== want.den)
                report_mismatch($sformatf("sum_den got %0d want %0d", den, want.den));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    far_in_if #(.OPERAND_WIDTH(OPW)) in_if ();
    far_out_if                       out_if ();

    fraction_add_reduce_core #(.OPERAND_WIDTH(OPW)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    sum_checker chk = new();
    bit         tx_quiet;
    bit         rx_quiet;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_num pick_num();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return NUM_MIN;
                    1:       return NUM_MAX;
                    2:       return '0;
                    3:       return t_num'(-1);
                    default: return t_num'(1);
                endcase
            end
            1, 2, 3: return t_num'(int'($urandom_range(0, 64)) - 32);
            default: return t_num'($urandom);
        endcase
    endfunction

    // Small denominators make reductions common; zero is kept rare
    function automatic t_den pick_den();
        int r;
        r = $urandom_range(0, 49);
        if (r == 0)
            return '0;
        if (r < 3)
            return DEN_MAX;
        if (r < 18)
            return t_den'($urandom_range(1, 16));
        if (r < 30)
            return t_den'($urandom_range(1, 255));
        return t_den'($urandom_range(1, int'(DEN_MAX)));
    endfunction

    // Offer one operand pair and wait for the transaction
    task automatic send_pair(t_num an, t_den ad, t_num bn, t_den bd);
        int gap;
        gap = idle_len(tx_quiet);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.a_num <= an;
        in_if.a_den <= ad;
        in_if.b_num <= bn;
        in_if.b_den <= bd;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        chk.note_operands(an, ad, bn, bd);
    endtask

    // Drop valid and hold until every pending sum has come back
    task automatic drain_sums();
        in_if.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (chk.owed() != 0);
    endtask

    // Result side: random back-pressure plus one long hold-off
    initial begin
        int  n_results;
        int  stall_left;
        int  cyc;
        bit  held;
        n_results  = 0;
        stall_left = 0;
        cyc        = 0;
        held       = 1'b0;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                chk.check_sum(out_if.sum_num, out_if.sum_den);
                n_results++;
            end
            if (cyc % 256 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            cyc++;
            if (n_results == HOLD_AT_RESULT && !held) begin
                // Long back-up: the core fills and stalls its input
                held = 1'b1;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                out_if.ready <= 1'b1;
            end else begin
                if (stall_left == 0 && !rx_quiet && $urandom_range(0, 5) == 0)
                    stall_left = idle_len(1'b0);
                if (stall_left > 0) begin
                    stall_left--;
                    out_if.ready <= 1'b0;
                end else begin
                    out_if.ready <= 1'b1;
                end
            end
        end
    end

    // Reset, directed pairs, random pairs, drain, verdict
    initial begin
        t_num an, bn;
        t_den ad, bd;
        i_rst_n     <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.a_num <= '0;
        in_if.a_den <= '0;
        in_if.b_num <= '0;
        in_if.b_den <= '0;
        tx_quiet = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero sums
        send_pair('0, 1, '0, 1);
        send_pair(1, 2, t_num'(-1), 2);
        send_pair(t_num'(-1), DEN_MAX, 1, DEN_MAX);
        send_pair(1, 1, t_num'(-1), 1);
        // Zero denominators: zero sum gives 0/1, otherwise +-1 over 0
        send_pair('0, '0, '0, '0);
        send_pair(t_num'(-5), '0, 3, '0);
        send_pair(5, '0, 3, 7);
        send_pair(t_num'(-1), '0, 2, 3);
        // Operand extremes
        send_pair(NUM_MIN, 1, NUM_MIN, 1);
        send_pair(NUM_MAX, 1, NUM_MAX, 1);
        send_pair(NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX);
        send_pair(NUM_MAX, DEN_MAX, NUM_MAX, DEN_MAX);
        send_pair(NUM_MAX, DEN_MAX, NUM_MIN, 1);
        send_pair(NUM_MIN, DEN_MAX, NUM_MAX, 1);
        send_pair(1, DEN_MAX, 1, DEN_MAX - 1);
        // Ordinary reductions
        send_pair(1, 2, 1, 2);
        send_pair(6, 4, 6, 4);
        send_pair(NUM_MAX, 2, 1, 2);
        send_pair(t_num'(-1), 1, t_num'(-1), 1);
        send_pair(NUM_MIN, 3, '0, 5);
        send_pair(12345, 30000, t_num'(-111), 29999);
        drain_sums();

        // Random pairs; some arranged to cancel or share a denominator
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 64 == 0)
                tx_quiet = ($urandom_range(0, 3) == 0);
            if (i == PAUSE_AT_ITEM)
                drain_sums();
            an = pick_num();
            ad = pick_den();
            case ($urandom_range(0, 11))
                0: begin
                    bn = -an;
                    bd = ad;
                end
                1: begin
                    bn = pick_num();
                    bd = ad;
                end
                default: begin
                    bn = pick_num();
                    bd = pick_den();
                end
            endcase
            send_pair(an, ad, bn, bd);
        end
        drain_sums();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (chk.n_mismatch == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Run limit
    initial begin
        #12_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
